@@ rtl/core/modbus_read_holding_master_core_macros.svh @@
// Assertion helpers for the Modbus read-holding master core.
`ifndef MODBUS_READ_HOLDING_MASTER_CORE_MACROS_SVH
`define MODBUS_READ_HOLDING_MASTER_CORE_MACROS_SVH

// Property checked on every rising edge outside reset.
`define MRHM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Condition that must never hold outside reset.
`define MRHM_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

`endif

@@ rtl/core/mrhm_pkg.sv @@
package mrhm_pkg;

    localparam logic       CMD_READ = 1'b0;
    localparam logic       CMD_RX   = 1'b1;

    localparam logic [7:0] FUNC_READ = 8'h03;

    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_REG    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] STAT_OK     = 3'd0;
    localparam logic [2:0] STAT_COUNT  = 3'd1;
    localparam logic [2:0] STAT_SHORT  = 3'd2;
    localparam logic [2:0] STAT_ADDR   = 3'd3;
    localparam logic [2:0] STAT_CRC    = 3'd4;
    localparam logic [2:0] STAT_BCOUNT = 3'd5;
    localparam logic [2:0] STAT_OVF    = 3'd6;

    localparam logic [1:0] SEL_TX   = 2'd0;
    localparam logic [1:0] SEL_REG  = 2'd1;
    localparam logic [1:0] SEL_STAT = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic       in_load;
        logic       req_load;
        logic       rx_byte;
        logic       frame_clear;
        logic       tx_fold;
        logic       idx_clear;
        logic       idx_next;
        logic       rd_lo;
        logic       hi_load;
        logic       out_load;
        logic [1:0] out_sel;
    } mrhm_cmd_t;

    typedef struct packed {
        logic in_is_rx;
        logic in_last;
        logic count_big;
        logic tx_final;
        logic emit_regs;
        logic reg_final;
    } mrhm_stat_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/core/mrhm_ctrl.sv @@
module mrhm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  mrhm_pkg::mrhm_stat_t st,
    output mrhm_pkg::mrhm_cmd_t  cmd
);
    import mrhm_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_TX_LOAD   = 4'd2;
    localparam logic [3:0] S_TX_WAIT   = 4'd3;
    localparam logic [3:0] S_CHECK     = 4'd4;
    localparam logic [3:0] S_STAT_WAIT = 4'd5;
    localparam logic [3:0] S_RD_HI     = 4'd6;
    localparam logic [3:0] S_RD_LO     = 4'd7;
    localparam logic [3:0] S_RD_OUT    = 4'd8;
    localparam logic [3:0] S_REG_WAIT  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       valid_reg, valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = valid_reg;

    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg;
        cmd        = '0;
        cmd.out_sel = SEL_TX;
        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.in_load = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!st.in_is_rx) begin
                    if (st.count_big) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = SEL_STAT;
                        valid_next   = 1'b1;
                        state_next   = S_STAT_WAIT;
                    end else begin
                        cmd.req_load  = 1'b1;
                        cmd.idx_clear = 1'b1;
                        state_next    = S_TX_LOAD;
                    end
                end else begin
                    cmd.rx_byte = 1'b1;
                    state_next  = st.in_last ? S_CHECK : S_IDLE;
                end
            end
            S_TX_LOAD: begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = SEL_TX;
                valid_next   = 1'b1;
                state_next   = S_TX_WAIT;
            end
            S_TX_WAIT: begin
                if (m_axis_tready) begin
                    valid_next   = 1'b0;
                    cmd.tx_fold  = 1'b1;
                    cmd.idx_next = 1'b1;
                    if (st.tx_final) begin
                        cmd.frame_clear = 1'b1;
                        state_next      = S_IDLE;
                    end else begin
                        state_next = S_TX_LOAD;
                    end
                end
            end
            S_CHECK: begin
                cmd.frame_clear = 1'b1;
                cmd.idx_clear   = 1'b1;
                if (st.emit_regs) begin
                    state_next = S_RD_HI;
                end else begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = SEL_STAT;
                    valid_next   = 1'b1;
                    state_next   = S_STAT_WAIT;
                end
            end
            S_STAT_WAIT: begin
                if (m_axis_tready) begin
                    valid_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            S_RD_HI: begin
                state_next = S_RD_LO;
            end
            S_RD_LO: begin
                cmd.rd_lo   = 1'b1;
                cmd.hi_load = 1'b1;
                state_next  = S_RD_OUT;
            end
            S_RD_OUT: begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = SEL_REG;
                valid_next   = 1'b1;
                state_next   = S_REG_WAIT;
            end
            S_REG_WAIT: begin
                if (m_axis_tready) begin
                    valid_next = 1'b0;
                    if (st.reg_final) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.idx_next = 1'b1;
                        state_next   = S_RD_HI;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/core/mrhm_dp.sv @@
module mrhm_dp #(
    parameter int MAX_REGS    = 64,
    parameter int FRAME_BYTES = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [47:0]          s_axis_tdata,
    input  logic                 s_axis_tlast,
    input  logic                 s_axis_tuser,
    input  mrhm_pkg::mrhm_cmd_t  cmd,
    output mrhm_pkg::mrhm_stat_t st,
    output logic [47:0]          m_axis_tdata,
    output logic                 m_axis_tlast,
    output logic [1:0]           m_axis_tuser
);
    import mrhm_pkg::*;

    localparam int AW    = $clog2(FRAME_BYTES);
    localparam int CNT_W = $clog2(FRAME_BYTES + 2);

    logic        in_cmd_reg;
    logic        in_last_reg;
    logic [7:0]  in_slave_reg;
    logic [15:0] in_start_reg;
    logic [15:0] in_count_reg;
    logic [7:0]  in_byte_reg;

    logic [7:0]       saved_slave_reg;
    logic [15:0]      saved_start_reg;
    logic [6:0]       saved_count_reg;
    logic [15:0]      crc_reg;
    logic [CNT_W-1:0] bytes_reg;
    logic [7:0]       byte0_reg;
    logic [7:0]       byte2_reg;
    logic [6:0]       idx_reg;
    logic [7:0]       hi_reg;
    logic [7:0]       rdata_reg;
    logic [7:0]       mem [FRAME_BYTES];

    logic [1:0]  out_kind_reg;
    logic [7:0]  out_tx_reg;
    logic [15:0] out_idx_reg;
    logic [15:0] out_val_reg;
    logic [2:0]  out_stat_reg;
    logic        out_last_reg;

    logic [7:0]  tx_byte;
    logic [2:0]  check_status;
    logic [2:0]  stat_code;
    logic [7:0]  rd_sum;
    logic [9:0]  need;
    logic [9:0]  n_ext;
    logic [6:0]  idx_inc;

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            in_cmd_reg   <= s_axis_tuser;
            in_last_reg  <= s_axis_tlast;
            in_slave_reg <= s_axis_tdata[7:0];
            in_start_reg <= s_axis_tdata[23:8];
            in_count_reg <= s_axis_tdata[39:24];
            in_byte_reg  <= s_axis_tdata[47:40];
        end
    end

    always_comb begin
        case (idx_reg[2:0])
            3'd0:    tx_byte = saved_slave_reg;
            3'd1:    tx_byte = FUNC_READ;
            3'd2:    tx_byte = saved_start_reg[15:8];
            3'd3:    tx_byte = saved_start_reg[7:0];
            3'd4:    tx_byte = 8'h00;
            3'd5:    tx_byte = {1'b0, saved_count_reg};
            3'd6:    tx_byte = crc_reg[7:0];
            default: tx_byte = crc_reg[15:8];
        endcase
    end

    assign need  = 10'd5 + {2'b00, saved_count_reg, 1'b0};
    assign n_ext = 10'(bytes_reg);

    always_comb begin
        if (bytes_reg > CNT_W'(FRAME_BYTES)) begin
            check_status = STAT_OVF;
        end else if (bytes_reg < CNT_W'(2)) begin
            check_status = STAT_SHORT;
        end else if (byte0_reg != saved_slave_reg) begin
            check_status = STAT_ADDR;
        end else if (crc_reg != 16'h0000) begin
            check_status = STAT_CRC;
        end else if (bytes_reg < CNT_W'(3)) begin
            check_status = STAT_SHORT;
        end else if (byte2_reg != {saved_count_reg, 1'b0}) begin
            check_status = STAT_BCOUNT;
        end else if (n_ext < need) begin
            check_status = STAT_SHORT;
        end else begin
            check_status = STAT_OK;
        end
    end

    assign stat_code = in_cmd_reg == CMD_READ ? STAT_COUNT : check_status;
    assign idx_inc   = idx_reg + 7'd1;

    assign st.in_is_rx  = (in_cmd_reg == CMD_RX);
    assign st.in_last   = in_last_reg;
    assign st.count_big = (in_count_reg > 16'(MAX_REGS));
    assign st.tx_final  = (idx_reg == 7'd7);
    assign st.emit_regs = (check_status == STAT_OK) && (saved_count_reg != 7'd0);
    assign st.reg_final = (idx_inc == saved_count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            saved_slave_reg <= 8'h00;
            saved_start_reg <= 16'h0000;
            saved_count_reg <= 7'd0;
            crc_reg         <= CRC_INIT;
            bytes_reg       <= '0;
            idx_reg         <= 7'd0;
        end else begin
            if (cmd.req_load) begin
                saved_slave_reg <= in_slave_reg;
                saved_start_reg <= in_start_reg;
                saved_count_reg <= in_count_reg[6:0];
            end
            if (cmd.req_load || cmd.frame_clear) begin
                crc_reg   <= CRC_INIT;
                bytes_reg <= '0;
            end else if (cmd.rx_byte) begin
                if (bytes_reg < CNT_W'(FRAME_BYTES)) begin
                    crc_reg   <= crc16_byte(crc_reg, in_byte_reg);
                    bytes_reg <= bytes_reg + CNT_W'(1);
                end else begin
                    bytes_reg <= CNT_W'(FRAME_BYTES + 1);
                end
            end else if (cmd.tx_fold && idx_reg < 7'd6) begin
                crc_reg <= crc16_byte(crc_reg, tx_byte);
            end
            if (cmd.idx_clear) begin
                idx_reg <= 7'd0;
            end else if (cmd.idx_next) begin
                idx_reg <= idx_inc;
            end
        end
    end

    // frame bytes 0 and 2 are kept aside for the header checks
    always_ff @(posedge aclk) begin
        if (cmd.rx_byte && bytes_reg == CNT_W'(0)) begin
            byte0_reg <= in_byte_reg;
        end
        if (cmd.rx_byte && bytes_reg == CNT_W'(2)) begin
            byte2_reg <= in_byte_reg;
        end
    end

    assign rd_sum = {idx_reg, 1'b0} + 8'd3 + {7'd0, cmd.rd_lo};

    always_ff @(posedge aclk) begin
        if (cmd.rx_byte && bytes_reg < CNT_W'(FRAME_BYTES)) begin
            mem[bytes_reg[AW-1:0]] <= in_byte_reg;
        end
        rdata_reg <= mem[rd_sum[AW-1:0]];
        if (cmd.hi_load) begin
            hi_reg <= rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_tx_reg   <= 8'h00;
            out_idx_reg  <= 16'h0000;
            out_val_reg  <= 16'h0000;
            out_stat_reg <= STAT_OK;
            out_last_reg <= 1'b1;
            case (cmd.out_sel)
                SEL_TX: begin
                    out_kind_reg <= KIND_TX;
                    out_tx_reg   <= tx_byte;
                    out_last_reg <= (idx_reg == 7'd7);
                end
                SEL_REG: begin
                    out_kind_reg <= KIND_REG;
                    out_idx_reg  <= saved_start_reg + {9'd0, idx_reg};
                    out_val_reg  <= {hi_reg, rdata_reg};
                    out_last_reg <= (idx_inc == saved_count_reg);
                end
                default: begin
                    out_kind_reg <= KIND_STATUS;
                    out_stat_reg <= stat_code;
                end
            endcase
        end
    end

    assign m_axis_tdata = {5'd0, out_stat_reg, out_val_reg, out_idx_reg, out_tx_reg};
    assign m_axis_tlast = out_last_reg;
    assign m_axis_tuser = out_kind_reg;

endmodule

@@ rtl/core/modbus_read_holding_master_core.sv @@
// Modbus RTU master for read holding registers (function 0x03). A request beat (tuser 0)
// with a count up to MAX_REGS produces the 8-byte request frame as kind-0 beats, CRC low
// byte first; a larger count gives a single count-too-big status. Response bytes (tuser 1)
// are stored and folded into a running CRC; the beat with tlast runs the checks and yields
// either one register beat per requested register (index = start + offset) or one status
// beat. One input beat is taken per pass through the controller (S_IDLE, S_DECODE, plus
// S_CHECK for the final byte). Each transmit byte passes S_TX_LOAD and S_TX_WAIT; each
// register value passes S_RD_HI, S_RD_LO, S_RD_OUT and S_REG_WAIT, paced by the single
// registered read port of the frame buffer. Result beats wait for m_axis_tready. No input
// is taken while results are outstanding. The frame buffer needs no clearing after reset.
module modbus_read_holding_master_core #(
    parameter int MAX_REGS    = 64,
    parameter int FRAME_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // slave_id[7:0], start_register[23:8], register_count[39:24], rx_byte[47:40]
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    // command
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_byte[7:0], register_index[23:8], register_value[39:24], status[42:40]
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tlast,
    // kind
    output logic [1:0]  m_axis_tuser
);
    import mrhm_pkg::*;

    mrhm_cmd_t  cmd;
    mrhm_stat_t st;

    mrhm_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .st            (st),
        .cmd           (cmd)
    );

    mrhm_dp #(
        .MAX_REGS    (MAX_REGS),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .s_axis_tuser (s_axis_tuser),
        .cmd          (cmd),
        .st           (st),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

`include "modbus_read_holding_master_core_macros.svh"

    `MRHM_ASSERT_NEVER(a_no_overlap, s_axis_tready && m_axis_tvalid, "input taken while result pending")
    `MRHM_ASSERT(a_big_count, s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_READ && s_axis_tdata[39:24] > 16'(MAX_REGS) |-> ##2 m_axis_tvalid && m_axis_tuser == KIND_STATUS && m_axis_tlast, "oversized count not rejected")
    `MRHM_ASSERT(a_status_last, m_axis_tvalid && m_axis_tuser == KIND_STATUS |-> m_axis_tlast, "status beat without tlast")

endmodule

@@ dv/modbus_read_holding_master_core_checker.sv @@
`timescale 1ns / 1ps
module modbus_read_holding_master_core_checker #(
    parameter int MAX_REGS    = 64,
    parameter int FRAME_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // slave_id[7:0], start_register[23:8], register_count[39:24], rx_byte[47:40]
    input  logic [47:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    // command
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tx_byte[7:0], register_index[23:8], register_value[39:24], status[42:40]
    input  logic [47:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    // kind
    input  logic [1:0]  m_axis_tuser,
    output int          fail_count,
    output int          beats_due
);
    import mrhm_pkg::*;

    localparam int AW = $clog2(FRAME_BYTES);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [15:0] reg_index;
        logic [15:0] reg_value;
        logic [2:0]  status;
        logic        last;
    } result_beat_t;

    result_beat_t due_q[$];
    int           errors = 0;

    logic [7:0]   slave_r;
    logic [15:0]  start_r;
    logic [6:0]   count_r;
    logic [15:0]  crc_r;
    logic [8:0]   rx_len;
    logic [7:0]   frame_mem [FRAME_BYTES];

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    task automatic push_beat(input logic [1:0] kind, input logic [7:0] tx,
                             input logic [15:0] idx, input logic [15:0] val,
                             input logic [2:0] st, input logic last);
        result_beat_t r;
        r.kind      = kind;
        r.tx_byte   = tx;
        r.reg_index = idx;
        r.reg_value = val;
        r.status    = st;
        r.last      = last;
        due_q.push_back(r);
    endtask

    task automatic predict_beat(input logic cmd, input logic [47:0] d, input logic end_flag);
        logic [7:0]  hdr [8];
        logic [15:0] cnt;
        logic [15:0] crc;
        logic [7:0]  b;
        int          n;
        if (cmd == CMD_READ) begin
            cnt = d[39:24];
            if (cnt > MAX_REGS) begin
                push_beat(KIND_STATUS, 8'h00, 16'h0000, 16'h0000, STAT_COUNT, 1'b1);
                return;
            end
            slave_r = d[7:0];
            start_r = d[23:8];
            count_r = cnt[6:0];
            crc_r   = CRC_INIT;
            rx_len  = '0;
            hdr[0]  = slave_r;
            hdr[1]  = FUNC_READ;
            hdr[2]  = start_r[15:8];
            hdr[3]  = start_r[7:0];
            hdr[4]  = cnt[15:8];
            hdr[5]  = cnt[7:0];
            crc     = CRC_INIT;
            for (int i = 0; i < 6; i++) crc = crc_fold(crc, hdr[i]);
            hdr[6] = crc[7:0];
            hdr[7] = crc[15:8];
            for (int i = 0; i < 8; i++) begin
                push_beat(KIND_TX, hdr[i], 16'h0000, 16'h0000, STAT_OK, i == 7);
            end
            return;
        end
        b = d[47:40];
        if (rx_len < FRAME_BYTES) begin
            frame_mem[rx_len[AW-1:0]] = b;
            rx_len                    = rx_len + 1'b1;
            crc_r                     = crc_fold(crc_r, b);
        end else begin
            rx_len = 9'(FRAME_BYTES + 1);
        end
        if (!end_flag) return;
        n      = rx_len;
        crc    = crc_r;
        rx_len = '0;
        crc_r  = CRC_INIT;
        if (n > FRAME_BYTES) begin
            push_beat(KIND_STATUS, 8'h00, 16'h0000, 16'h0000, STAT_OVF, 1'b1);
        end else if (n < 2) begin
            push_beat(KIND_STATUS, 8'h00, 16'h0000, 16'h0000, STAT_SHORT, 1'b1);
        end else if (frame_mem[0] != slave_r) begin
            push_beat(KIND_STATUS, 8'h00, 16'h0000, 16'h0000, STAT_ADDR, 1'b1);
        end else if (crc != 16'h0000) begin
            push_beat(KIND_STATUS, 8'h00, 16'h0000, 16'h0000, STAT_CRC, 1'b1);
        end else if (n < 3) begin
            push_beat(KIND_STATUS, 8'h00, 16'h0000, 16'h0000, STAT_SHORT, 1'b1);
        end else if (frame_mem[2] != {count_r, 1'b0}) begin
            push_beat(KIND_STATUS, 8'h00, 16'h0000, 16'h0000, STAT_BCOUNT, 1'b1);
        end else if (n < 5 + 2 * count_r) begin
            push_beat(KIND_STATUS, 8'h00, 16'h0000, 16'h0000, STAT_SHORT, 1'b1);
        end else if (count_r == 0) begin
            push_beat(KIND_STATUS, 8'h00, 16'h0000, 16'h0000, STAT_OK, 1'b1);
        end else begin
            for (int j = 0; j < count_r; j++) begin
                push_beat(KIND_REG, 8'h00, start_r + j[15:0],
                          {frame_mem[AW'(3 + 2 * j)], frame_mem[AW'(4 + 2 * j)]},
                          STAT_OK, j == count_r - 1);
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        result_beat_t want;
        if (!aresetn) begin
            slave_r = '0;
            start_r = '0;
            count_r = '0;
            crc_r   = CRC_INIT;
            rx_len  = '0;
            due_q.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_beat(s_axis_tuser, s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_q.size() == 0) begin
                    $error("result beat with nothing due: kind %0d data 0x%0h",
                           m_axis_tuser, m_axis_tdata);
                    errors++;
                end else begin
                    want = due_q.pop_front();
                    check_field("kind", 16'(want.kind), 16'(m_axis_tuser));
                    check_field("tx_byte", 16'(want.tx_byte), 16'(m_axis_tdata[7:0]));
                    check_field("register_index", want.reg_index, m_axis_tdata[23:8]);
                    check_field("register_value", want.reg_value, m_axis_tdata[39:24]);
                    check_field("status", 16'(want.status), 16'(m_axis_tdata[42:40]));
                    check_field("last", 16'(want.last), 16'(m_axis_tlast));
                end
            end
        end
        beats_due  <= due_q.size();
        fail_count <= errors;
    end

endmodule

@@ dv/tb_modbus_read_holding_master_core.sv @@
`timescale 1ns / 1ps
module tb_modbus_read_holding_master_core;
    import mrhm_pkg::*;

    localparam int MAX_REGS     = 64;
    localparam int FRAME_BYTES  = 256;
    localparam int RANDOM_BEATS = 100;
    localparam int IDLE_PCT     = 14;
    localparam int TAIL_CYCLES  = 300;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;
    int          fail_count;
    int          beats_due;

    bit          calm = 1'b0;
    int          beats_sent = 0;
    logic [7:0]  frame_buf[$];

    modbus_read_holding_master_core #(
        .MAX_REGS    (MAX_REGS),
        .FRAME_BYTES (FRAME_BYTES)
    ) i_dut (.*);

    modbus_read_holding_master_core_checker #(
        .MAX_REGS    (MAX_REGS),
        .FRAME_BYTES (FRAME_BYTES)
    ) i_checker (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    task automatic send_beat(input logic cmd, input logic [47:0] data, input logic end_flag);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= end_flag;
        s_axis_tuser  <= cmd;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic send_request(input logic [7:0] slave, input logic [15:0] start,
                                input logic [15:0] count);
        logic [7:0] junk;
        logic       junk_last;
        junk      = 8'($urandom_range(255));
        junk_last = 1'($urandom_range(1));
        send_beat(CMD_READ, {junk, count, start, slave}, junk_last);
    endtask

    task automatic send_rx(input logic [7:0] b, input logic end_flag);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        send_beat(CMD_RX, {b, junk[39:0]}, end_flag);
    endtask

    // build slave, function, byte count, data, pad, CRC; optionally corrupt or cut it
    task automatic send_reply(input logic [7:0] slave, input logic [7:0] bcount,
                              input int data_len, input int pad, input bit bad_crc,
                              input int keep);
        logic [15:0] crc;
        logic [7:0]  rnd;
        int          pos;
        int          total;
        frame_buf.delete();
        frame_buf.push_back(slave);
        frame_buf.push_back(FUNC_READ);
        frame_buf.push_back(bcount);
        for (int i = 0; i < data_len + pad; i++) begin
            rnd = 8'($urandom_range(255));
            frame_buf.push_back(rnd);
        end
        crc = CRC_INIT;
        foreach (frame_buf[i]) crc = crc_update(crc, frame_buf[i]);
        frame_buf.push_back(crc[7:0]);
        frame_buf.push_back(crc[15:8]);
        if (bad_crc) begin
            pos            = $urandom_range(1, frame_buf.size() - 1);
            rnd            = 8'($urandom_range(1, 255));
            frame_buf[pos] = frame_buf[pos] ^ rnd;
        end
        total = (keep > 0) ? keep : frame_buf.size();
        for (int i = 0; i < total; i++) send_rx(frame_buf[i], i == total - 1);
    endtask

    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (beats_due != 0) @(posedge aclk);
    endtask

    task automatic run_exchange;
        logic [7:0]  slave;
        logic [7:0]  reply_slave;
        logic [7:0]  bcount;
        logic [7:0]  flip;
        logic [15:0] start;
        int          n;
        int          pick;
        int          data_len;
        int          pad;
        bit          bad_crc;
        int          keep;
        slave = 8'($urandom_range(255));
        start = 16'($urandom_range(65535));
        pick  = $urandom_range(99);
        if (pick < 8) begin
            send_request(slave, start, 16'($urandom_range(MAX_REGS + 1, 65535)));
            return;
        end
        if (pick < 14) begin
            repeat ($urandom_range(1, 3)) begin
                send_rx(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
            return;
        end
        n = ($urandom_range(19) == 0) ? $urandom_range(0, MAX_REGS) : $urandom_range(0, 4);
        send_request(slave, start, 16'(n));
        if ($urandom_range(19) == 0) return;
        reply_slave = slave;
        bcount      = 8'(2 * n);
        data_len    = 2 * n;
        pad         = 0;
        bad_crc     = 1'b0;
        keep        = 0;
        flip        = 8'($urandom_range(1, 255));
        pick        = $urandom_range(99);
        if (pick < 60) begin
        end else if (pick < 68) begin
            pad = $urandom_range(1, 6);
        end else if (pick < 76) begin
            bad_crc = 1'b1;
        end else if (pick < 82) begin
            reply_slave = slave ^ flip;
        end else if (pick < 88) begin
            bcount = bcount ^ flip;
        end else if (pick < 94) begin
            if (n > 0) data_len = $urandom_range(0, 2 * n - 1);
        end else begin
            keep = $urandom_range(1, 4 + 2 * n);
        end
        send_reply(reply_slave, bcount, data_len, pad, bad_crc, keep);
    endtask

    initial begin
        int mark;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reply before any request, checked against the reset values
        send_reply(8'h00, 8'h00, 0, 0, 1'b0, 0);
        send_request(8'hFF, 16'hFFFF, 16'h0000);
        // two-byte frame whose CRC residue is zero
        send_rx(8'hFF, 1'b0);
        send_rx(8'hFF, 1'b1);
        send_request(8'h12, 16'h0000, 16'(MAX_REGS + 1));
        send_request(8'h00, 16'h0000, 16'hFFFF);
        send_rx(8'($urandom_range(255)), 1'b1);
        send_request(8'hA5, 16'hFFFF, 16'h0002);
        send_reply(8'hA5, 8'h04, 4, 0, 1'b0, 0);
        wait_drained();

        // full-size frame at the store limit, then one byte over it, with no idling
        calm = 1'b1;
        send_request(8'h5A, 16'h8000, 16'(MAX_REGS));
        send_reply(8'h5A, 8'(2 * MAX_REGS), 2 * MAX_REGS, FRAME_BYTES - 5 - 2 * MAX_REGS,
                   1'b0, 0);
        send_request(8'h01, 16'h0001, 16'h0001);
        send_reply(8'h01, 8'h02, FRAME_BYTES - 4, 0, 1'b0, 0);
        wait_drained();
        calm = 1'b0;

        mark = beats_sent;
        while (beats_sent - mark < RANDOM_BEATS) begin
            run_exchange();
            if ($urandom_range(19) == 0) wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && beats_due == 0) begin
            $display("tb_modbus_read_holding_master_core: PASS");
        end else begin
            $display("tb_modbus_read_holding_master_core: FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_modbus_read_holding_master_core: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/mrhm_pkg.sv
rtl/core/mrhm_ctrl.sv
rtl/core/mrhm_dp.sv
rtl/core/modbus_read_holding_master_core.sv
dv/modbus_read_holding_master_core_checker.sv
dv/tb_modbus_read_holding_master_core.sv
